>>> rtl/core/bcd_pkg.sv
// Shared types, codes and reset constants of the button click and hold detector.
package bcd_pkg;

    localparam int unsigned TimeW     = 16;
    localparam int unsigned MsW       = 8;
    localparam int unsigned EventW    = 2;
    localparam int unsigned AddrW     = 4;
    localparam int unsigned DataW     = 32;

    localparam logic [TimeW-1:0] ClickResetMs   = 16'd20;
    localparam logic [TimeW-1:0] ReleaseResetMs = 16'd20;
    localparam logic [TimeW-1:0] HoldResetMs    = 16'd800;
    localparam logic [TimeW-1:0] AccMax         = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_ACTIVE_LEVEL = 2'd0,
        REG_CLICK_MIN    = 2'd1,
        REG_RELEASE_MIN  = 2'd2,
        REG_HOLD_MIN     = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_DETECT   = 4'b0001,
        PH_DEBOUNCE = 4'b0010,
        PH_HOLD     = 4'b0100,
        PH_RELEASE  = 4'b1000
    } t_phase;

    typedef enum logic [EventW-1:0] {
        EV_IDLE  = 2'd0,
        EV_CLICK = 2'd1,
        EV_HOLD  = 2'd2
    } t_event;

    typedef struct packed {
        logic             active_level;
        logic [TimeW-1:0] click_min_ms;
        logic [TimeW-1:0] release_min_ms;
        logic [TimeW-1:0] hold_min_ms;
    } t_cfg;

endpackage

>>> rtl/core/bcd_regs.sv
// Configuration register file with its APB-style access port.
module bcd_regs
    import bcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[AddrW-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level   <= 1'b0;
            r_cfg.click_min_ms   <= ClickResetMs;
            r_cfg.release_min_ms <= ReleaseResetMs;
            r_cfg.hold_min_ms    <= HoldResetMs;
        end else if (w_wr) begin
            case (w_idx)
                REG_ACTIVE_LEVEL: r_cfg.active_level   <= pwdata[0];
                REG_CLICK_MIN:    r_cfg.click_min_ms   <= pwdata[TimeW-1:0];
                REG_RELEASE_MIN:  r_cfg.release_min_ms <= pwdata[TimeW-1:0];
                REG_HOLD_MIN:     r_cfg.hold_min_ms    <= pwdata[TimeW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ACTIVE_LEVEL: prdata = {{(DataW-1){1'b0}}, r_cfg.active_level};
            REG_CLICK_MIN:    prdata = {{(DataW-TimeW){1'b0}}, r_cfg.click_min_ms};
            REG_RELEASE_MIN:  prdata = {{(DataW-TimeW){1'b0}}, r_cfg.release_min_ms};
            REG_HOLD_MIN:     prdata = {{(DataW-TimeW){1'b0}}, r_cfg.hold_min_ms};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/bcd_fsm.sv
// Phase machine and saturating time accumulator, updated once per item.
module bcd_fsm
    import bcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_level,
    input  logic [MsW-1:0]   i_elapsed_ms,
    input  t_cfg             i_cfg,
    output t_event           o_event
);

    t_phase           r_phase;
    t_phase           n_phase;
    logic [TimeW-1:0] r_accum;
    logic [TimeW-1:0] n_accum;
    logic [TimeW:0]   w_sum;
    logic [TimeW-1:0] w_sat;
    logic             w_pressed;

    assign w_pressed = (i_level == i_cfg.active_level);
    assign w_sum     = {1'b0, r_accum} + {{(TimeW+1-MsW){1'b0}}, i_elapsed_ms};
    assign w_sat     = w_sum[TimeW] ? AccMax : w_sum[TimeW-1:0];

    always_comb begin
        n_phase = r_phase;
        n_accum = r_accum;
        o_event = EV_IDLE;
        case (r_phase)
            PH_DETECT: begin
                if (w_pressed) begin
                    n_accum = '0;
                    n_phase = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (w_pressed) begin
                    n_accum = w_sat;
                    if (w_sat > i_cfg.hold_min_ms) begin
                        n_accum = '0;
                        n_phase = PH_HOLD;
                        o_event = EV_HOLD;
                    end
                end else if (r_accum > i_cfg.click_min_ms) begin
                    n_accum = '0;
                    n_phase = PH_RELEASE;
                    o_event = EV_CLICK;
                end else begin
                    // A bounce shorter than the click time: accumulator is left as is.
                    n_phase = PH_DETECT;
                end
            end
            PH_HOLD, PH_RELEASE: begin
                if (w_pressed) begin
                    if (r_phase == PH_HOLD) begin
                        o_event = EV_HOLD;
                    end
                    n_accum = '0;
                end else begin
                    n_accum = w_sat;
                    if (w_sat > i_cfg.release_min_ms) begin
                        n_accum = '0;
                        n_phase = PH_DETECT;
                    end
                end
            end
            default: begin
                n_phase = PH_DETECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DETECT;
            r_accum <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
        end
    end

    a_hold_enters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_event == EV_HOLD) |=> (r_phase == PH_HOLD) && (r_accum == '0))
        else $error("hold event did not leave the machine in hold with a clear accumulator");

    a_click_enters_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_event == EV_CLICK) |=> (r_phase == PH_RELEASE) && (r_accum == '0))
        else $error("click event did not leave the machine in release");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_accum))
        else $error("state changed without an item");

    a_click_from_debounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_event == EV_CLICK) |-> (r_phase == PH_DEBOUNCE) && !w_pressed)
        else $error("click reported outside a debounce release");

endmodule

>>> rtl/core/button_click_hold_detector_core.sv
// Top level of the button click and hold detector: handshakes, item and result registers.
//
// Each accepted item is one scan tick (pin level plus milliseconds since the last
// scan) and yields exactly one event code: idle, click or hold. The block takes one
// item per clock cycle unless the result register is full and stalled. An item waits
// in the item register until the result register is empty or being taken; its result
// is then written into the result register and offered there. The rate is set by
// the phase and accumulator update, a loop of one 16-bit saturating add and compare.
// Configuration registers sit at byte addresses 0, 4, 8 and 12 and are to be written
// only while no items are in flight.
module button_click_hold_detector_core
    import bcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_level,
    input  logic [MsW-1:0]    i_elapsed_ms,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [EventW-1:0] o_event_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready
);

    t_cfg           w_cfg;
    t_event         w_event;
    logic           r_in_vld;
    logic           r_level;
    logic [MsW-1:0] r_elapsed_ms;
    logic           r_out_vld;
    t_event         r_event;
    logic           w_adv;
    logic           w_step;
    logic           w_in_acc;

    // The item register moves on whenever the result register is empty or being taken.
    assign w_adv      = !r_out_vld || !i_out_stall;
    assign w_step     = r_in_vld && w_adv;
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    bcd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bcd_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_level      (r_level),
        .i_elapsed_ms (r_elapsed_ms),
        .i_cfg        (w_cfg),
        .o_event      (w_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_step) begin
                r_in_vld <= 1'b0;
            end
            if (w_step) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_level      <= i_level;
            r_elapsed_ms <= i_elapsed_ms;
        end
        if (w_step) begin
            r_event <= w_event;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_event_res = r_event;

endmodule
